// ----- hdl/word_token_extractor_top_defines.svh -----
// Assertion macros shared by the word token extractor RTL.
`ifndef WORD_TOKEN_EXTRACTOR_TOP_DEFINES_SVH
`define WORD_TOKEN_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/wte_pkg.sv -----
// Shared types, constants and byte classification for the word token extractor.
package wte_pkg;

  localparam int WORD_MAX_DEF    = 32;
  localparam int PENDING_MAX_DEF = 8;
  localparam int TOKQ_DEPTH      = 2;   // power of two
  localparam int OUTQ_DEPTH      = 4;   // power of two
  localparam int LEN_W           = 6;

  localparam logic [7:0] HIGH_BIT    = 8'h80;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_UNDER    = 8'h5f;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_FLUSH   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_LETTER,
    CLS_DOLLAR,
    CLS_JOINER,
    CLS_OTHER
  } byte_class_t;

  typedef enum logic [1:0] {
    M_START,
    M_WAITING,
    M_IN_WORD,
    M_JOIN_RUN
  } scan_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_DRAIN
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    byte_class_t cls;
    logic [7:0]  chr;
  } tok_t;

  typedef struct packed {
    logic [7:0]       chr;
    logic             last;
    logic             trunc;
    logic [LEN_W-1:0] len;
  } res_t;

  localparam int TOK_W = $bits(tok_t);
  localparam int RES_W = $bits(res_t);

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t cls;
    cls = CLS_OTHER;
    if ((c & HIGH_BIT) != 8'd0 || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
        (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
        c == CH_PERCENT) begin
      cls = CLS_LETTER;
    end else if (c == CH_DOLLAR) begin
      cls = CLS_DOLLAR;
    end else if (c == CH_DOT || c == CH_MINUS || c == CH_PLUS || c == CH_COMMA ||
                 c == CH_UNDER) begin
      cls = CLS_JOINER;
    end
    return cls;
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ----- hdl/word_token_extractor_top.sv -----
// Top level of the word token extractor: front end, back end and result queue.
//
// Word token extractor. Input transactions carry a command (data byte, end-of-input
// flush, restart) and a byte; result transactions carry one lower-cased byte of a
// finished word with its last mark, truncation flag and word length. Both sides are
// queues: an input transaction completes on push while full is low, a result
// transaction on pop while empty is low. A front end classifies each byte and puts it
// in a two-entry token queue; the back end runs the scan state machine against the
// word store (a RAM of WORD_MAX bytes) and a small RAM of PENDING_MAX pending
// specials, then drains finished words into a four-entry result queue. A letter that
// ends a pending run starts a merge, which writes one byte per cycle into the single
// write port of the word store: each pending special in turn, then the letter; a word
// drain is paced by the registered read port of the word store and by room in the
// result queue. Words and pending runs longer than their stores are cut short and
// flagged as truncated. No clearing pass is needed after reset: only written entries
// are read.
module word_token_extractor_top
  import wte_pkg::*;
#(
  parameter int WORD_MAX    = WORD_MAX_DEF,
  parameter int PENDING_MAX = PENDING_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // input transactions
  input  logic             push,
  output logic             full,
  input  logic [1:0]       command,
  input  logic [7:0]       data_byte,
  // result transactions
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       token_byte,
  output logic             last,
  output logic             truncated,
  output logic [LEN_W-1:0] token_length
);

  localparam int OCW = $clog2(OUTQ_DEPTH + 1);

  tok_t             tok;
  logic             tok_empty;
  logic             tok_pop;
  logic             res_push;
  res_t             res;
  logic [RES_W-1:0] res_rd;
  res_t             res_head;
  logic             outq_full;
  logic [OCW-1:0]   out_count;

  // Front end: accepts and classifies input transactions.
  wte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .data_byte (data_byte),
    .tok       (tok),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop)
  );

  // Back end: scan modes, stores, word emission.
  wte_back #(
    .WORD_MAX    (WORD_MAX),
    .PENDING_MAX (PENDING_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_push  (res_push),
    .res       (res),
    .out_count (out_count)
  );

  // Result queue; the back end only issues reads when a slot is reserved,
  // so outq_full never blocks a push.
  wte_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (outq_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty),
    .count   (out_count)
  );

  assign res_head     = res_t'(res_rd);
  assign token_byte   = res_head.chr;
  assign last         = res_head.last;
  assign truncated    = res_head.trunc;
  assign token_length = res_head.len;

  `include "word_token_extractor_top_defines.svh"

  `WTE_ASSERT_NOW(a_no_push_when_full, res_push, !outq_full, "result push while queue full")
  `WTE_ASSERT_NEXT(a_head_held, !empty && !pop, !empty && res_rd == $past(res_rd), "waiting result changed")
  `WTE_ASSERT_NEXT(a_empty_held, empty && !res_push, empty, "result queue filled with no push")

endmodule

// ----- hdl/wte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/wte_fifo.sv -----
// Small register-based FIFO; depth must be a power of two.
module wte_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic [CNTW-1:0]  count
);

  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/wte_front.sv -----
// Front end: takes input transactions, classifies bytes, queues tokens for the back end.
module wte_front
  import wte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  output tok_t       tok,
  output logic       tok_empty,
  input  logic       tok_pop
);

  localparam int CNTW = $clog2(TOKQ_DEPTH + 1);

  tok_t             tok_in;
  logic             enq;
  logic [TOK_W-1:0] q_rd;
  logic [CNTW-1:0]  q_count;

  // Unused command code is accepted and dropped here.
  assign enq = push && !full &&
               (command == CMD_DATA || command == CMD_FLUSH || command == CMD_RESTART);

  always_comb begin
    tok_in.cmd = cmd_t'(command);
    tok_in.cls = classify(data_byte);
    tok_in.chr = fold_lower(data_byte);
  end

  wte_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (TOKQ_DEPTH)
  ) u_tokq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_data (tok_in),
    .full    (full),
    .rd_en   (tok_pop),
    .rd_data (q_rd),
    .empty   (tok_empty),
    .count   (q_count)
  );

  assign tok = tok_t'(q_rd);

endmodule

// ----- hdl/wte_back.sv -----
// Back end: scan state machine, word and pending stores, word drain.
`include "word_token_extractor_top_defines.svh"

module wte_back
  import wte_pkg::*;
#(
  parameter int WORD_MAX    = WORD_MAX_DEF,
  parameter int PENDING_MAX = PENDING_MAX_DEF,
  localparam int OCW        = $clog2(OUTQ_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  tok_t           tok,
  input  logic           tok_empty,
  output logic           tok_pop,
  output logic           res_push,
  output res_t           res,
  input  logic [OCW-1:0] out_count
);

  localparam int CW  = $clog2(WORD_MAX + 1);
  localparam int AW  = $clog2(WORD_MAX);
  localparam int PCW = $clog2(PENDING_MAX + 1);
  localparam int PAW = (PENDING_MAX > 1) ? $clog2(PENDING_MAX) : 1;
  localparam logic [CW-1:0]  WMAX_C = CW'(WORD_MAX);
  localparam logic [PCW-1:0] PMAX_C = PCW'(PENDING_MAX);
  localparam logic [OCW:0]   OQ_C   = (OCW + 1)'(OUTQ_DEPTH);

  back_state_t    state, state_next;
  scan_mode_t     mode, mode_next;
  logic [CW-1:0]  wc, wc_next;
  logic [PCW-1:0] pc, pc_next;
  logic           ovf, ovf_next;
  logic [PCW-1:0] mk, mk_next;
  logic [CW-1:0]  rd_idx, rd_idx_next;
  logic           inflight;
  logic           last_q, last_q_next;
  logic           issue;

  logic           pend_we;
  logic [7:0]     pend_rd;

  logic           ram_we;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  wte_ram #(
    .WIDTH (8),
    .DEPTH (WORD_MAX)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wc[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Pending specials. Read address follows mk_next so that pend_rd holds
  // entry mk during each merge cycle.
  wte_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_MAX)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pc[PAW-1:0]),
    .wdata (tok.chr),
    .raddr (mk_next[PAW-1:0]),
    .rdata (pend_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= M_START;
      wc       <= '0;
      pc       <= '0;
      ovf      <= 1'b0;
      mk       <= '0;
      rd_idx   <= '0;
      inflight <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      wc       <= wc_next;
      pc       <= pc_next;
      ovf      <= ovf_next;
      mk       <= mk_next;
      rd_idx   <= rd_idx_next;
      inflight <= issue;
      last_q   <= last_q_next;
    end
  end

  // Read data lands in the cycle after issue.
  assign res_push  = inflight;
  assign res.chr   = ram_rdata;
  assign res.last  = last_q;
  assign res.trunc = ovf;
  assign res.len   = LEN_W'(wc);

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    wc_next     = wc;
    pc_next     = pc;
    ovf_next    = ovf;
    mk_next     = mk;
    rd_idx_next = rd_idx;
    last_q_next = last_q;
    issue       = 1'b0;
    tok_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = tok.chr;
    pend_we     = 1'b0;

    case (state)
      S_IDLE: begin
        if (!tok_empty) begin
          case (tok.cmd)
            CMD_FLUSH: begin
              tok_pop = 1'b1;
              if ((mode == M_IN_WORD || mode == M_JOIN_RUN) && wc != '0) begin
                state_next  = S_DRAIN;
                rd_idx_next = '0;
              end else begin
                mode_next = M_START;
                wc_next   = '0;
                pc_next   = '0;
                ovf_next  = 1'b0;
              end
            end
            CMD_RESTART: begin
              tok_pop   = 1'b1;
              mode_next = M_START;
              wc_next   = '0;
              pc_next   = '0;
              ovf_next  = 1'b0;
            end
            CMD_DATA: begin
              case (mode)
                M_IN_WORD: begin
                  tok_pop = 1'b1;
                  if (tok.cls == CLS_LETTER) begin
                    if (wc < WMAX_C) begin
                      ram_we  = 1'b1;
                      wc_next = wc + 1'b1;
                    end else begin
                      ovf_next = 1'b1;
                    end
                  end else if (tok.cls == CLS_JOINER || tok.cls == CLS_DOLLAR) begin
                    mode_next = M_JOIN_RUN;
                    if (pc < PMAX_C) begin
                      pend_we = 1'b1;
                      pc_next = pc + 1'b1;
                    end else begin
                      ovf_next = 1'b1;
                    end
                  end else begin
                    state_next  = S_DRAIN;
                    rd_idx_next = '0;
                  end
                end
                M_JOIN_RUN: begin
                  if (tok.cls == CLS_LETTER) begin
                    // Token stays at the head until the merge ends.
                    state_next = S_MERGE;
                    mk_next    = '0;
                  end else if (tok.cls == CLS_JOINER || tok.cls == CLS_DOLLAR) begin
                    tok_pop = 1'b1;
                    if (pc < PMAX_C) begin
                      pend_we = 1'b1;
                      pc_next = pc + 1'b1;
                    end else begin
                      ovf_next = 1'b1;
                    end
                  end else begin
                    tok_pop     = 1'b1;
                    state_next  = S_DRAIN;
                    rd_idx_next = '0;
                  end
                end
                default: begin
                  // start and waiting behave alike
                  tok_pop  = 1'b1;
                  pc_next  = '0;
                  ovf_next = 1'b0;
                  if (tok.cls == CLS_LETTER || tok.cls == CLS_DOLLAR) begin
                    // word_count is zero here in effect: write entry 0
                    ram_we    = 1'b1;
                    wc_next   = CW'(1);
                    mode_next = M_IN_WORD;
                  end else begin
                    wc_next   = '0;
                    mode_next = M_WAITING;
                  end
                end
              endcase
            end
            default: begin
              tok_pop = 1'b1;
            end
          endcase
        end
      end

      S_MERGE: begin
        if (mk < pc) begin
          ram_wdata = pend_rd;
          mk_next   = mk + 1'b1;
        end else begin
          tok_pop    = 1'b1;
          pc_next    = '0;
          mode_next  = M_IN_WORD;
          state_next = S_IDLE;
        end
        if (wc < WMAX_C) begin
          ram_we  = 1'b1;
          wc_next = wc + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end

      S_DRAIN: begin
        if (rd_idx != wc) begin
          if (({1'b0, out_count} + (OCW + 1)'(inflight)) < OQ_C) begin
            issue       = 1'b1;
            last_q_next = (rd_idx == wc - 1'b1);
            rd_idx_next = rd_idx + 1'b1;
          end
        end else if (!inflight) begin
          state_next = S_IDLE;
          mode_next  = M_START;
          wc_next    = '0;
          pc_next    = '0;
          ovf_next   = 1'b0;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `WTE_ASSERT_NOW(a_pending_nonempty, state == S_IDLE && mode == M_JOIN_RUN, pc != '0, "pending mode with empty pending store")
  `WTE_ASSERT_NOW(a_merge_head_letter, state == S_MERGE, !tok_empty && tok.cls == CLS_LETTER && tok.cmd == CMD_DATA, "merge without a letter at queue head")
  `WTE_ASSERT_NOW(a_result_room, res_push, out_count < OCW'(OUTQ_DEPTH), "result pushed into full output queue")
  `WTE_ASSERT_NEXT(a_drain_nonempty, state != S_DRAIN && state_next == S_DRAIN, wc != '0 && rd_idx == '0, "drain started on empty word")

endmodule
